// ===== rtl/scu_pkg.sv =====
package scu_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int COL_W    = 13;
	localparam int WEFF_W   = 15;
	localparam int PREC_W   = 5;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Chroma layout codes; the unused code acts as 4:4:4
	typedef enum logic [1:0] {
		MODE_444 = 2'd0,
		MODE_422 = 2'd1,
		MODE_420 = 2'd2
	} mode_e_t;

	// Register word indexes
	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_PREC  = 2'd1,
		REG_WIDTH = 2'd2
	} reg_idx_t;

	// Q16 coefficients
	localparam logic signed [17:0] COEF_R  = 18'sd91881;
	localparam logic signed [17:0] COEF_GB = 18'sd22544;
	localparam logic signed [17:0] COEF_GR = 18'sd46793;
	localparam logic signed [17:0] COEF_B  = 18'sd116130;

	// Effective configuration seen by the datapath
	typedef struct packed {
		logic [1:0]        mode;
		logic [PREC_W-1:0] prec;
		logic [WEFF_W-1:0] width;
	} cfg_t;

	// Item entering the color math, chroma pair already resolved
	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] cb;
		logic [SAMPLE_W-1:0] cr;
	} math_in_t;

	// Divide by 65536, truncating toward zero
	function automatic logic signed [19:0] trunc_q16(input logic signed [35:0] p);
		logic signed [35:0] a;
		a = p + (p[35] ? 36'sd65535 : 36'sd0);
		return 20'(a >>> 16);
	endfunction

	// Saturate to [0, upb]
	function automatic logic [SAMPLE_W-1:0] clamp_comp(input logic signed [20:0] v,
			input logic [SAMPLE_W-1:0] upb);
		logic [SAMPLE_W-1:0] r;
		if (v < 21'sd0) begin
			r = '0;
		end else if (v > $signed({5'b0, upb})) begin
			r = upb;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/scu_stream_if.sv =====
// Input pixel channel
interface scu_pix_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] luma;
	logic [15:0] chroma_blue;
	logic [15:0] chroma_red;
	logic        frame_start;

	modport source (output valid, luma, chroma_blue, chroma_red, frame_start, input ready);
	modport sink (input valid, luma, chroma_blue, chroma_red, frame_start, output ready);
endinterface

// Output pixel channel
interface scu_pix_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/scu_cfg_regs.sv =====
module scu_cfg_regs #(
	parameter int MAX_WIDTH   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scu_pkg::ADDR_W-1:0]   paddr,
	input  logic [scu_pkg::DATA_W-1:0]   pwdata,
	output logic [scu_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output scu_pkg::cfg_t                cfg
);

	localparam logic [scu_pkg::WEFF_W-1:0] MAXW = scu_pkg::WEFF_W'(MAX_WIDTH);
	localparam logic [scu_pkg::PREC_W-1:0] MAXP = scu_pkg::PREC_W'(SAMPLE_BITS);

	logic [1:0]                      mode_q;
	logic [scu_pkg::PREC_W-1:0]      prec_q;
	logic [scu_pkg::COL_W-1:0]       width_q;
	logic                            wr_en;
	logic [1:0]                      idx;
	logic [scu_pkg::WEFF_W-1:0]      w_ext;
	logic [scu_pkg::WEFF_W-1:0]      w_clamp;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= scu_pkg::MODE_444;
			prec_q  <= 5'd8;
			width_q <= 13'd640;
		end else if (wr_en) begin
			case (idx)
				scu_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
				scu_pkg::REG_PREC:  prec_q  <= pwdata[4:0];
				scu_pkg::REG_WIDTH: width_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			scu_pkg::REG_MODE:  prdata = {30'b0, mode_q};
			scu_pkg::REG_PREC:  prdata = {27'b0, prec_q};
			scu_pkg::REG_WIDTH: prdata = {19'b0, width_q};
			default:            prdata = '0;
		endcase
	end

	// Effective values: precision within [1, SAMPLE_BITS], width even within [2, MAX_WIDTH]
	always_comb begin
		w_ext = {2'b0, width_q};
		if (w_ext < 15'd2) begin
			w_clamp = 15'd2;
		end else if (w_ext > MAXW) begin
			w_clamp = MAXW;
		end else begin
			w_clamp = w_ext;
		end
		cfg.mode  = mode_q;
		cfg.width = {w_clamp[scu_pkg::WEFF_W-1:1], 1'b0};
		if (prec_q == '0) begin
			cfg.prec = 5'd1;
		end else if (prec_q > MAXP) begin
			cfg.prec = MAXP;
		end else begin
			cfg.prec = prec_q;
		end
	end

endmodule

// ===== rtl/scu_line_mem.sv =====
module scu_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// Single port: reads and writes share one address, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/scu_color_math.sv =====
module scu_color_math (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  scu_pkg::math_in_t             in_s1,
	input  logic [scu_pkg::PREC_W-1:0]    prec,
	output logic                          valid_q,
	output logic [scu_pkg::SAMPLE_W-1:0]  red_q,
	output logic [scu_pkg::SAMPLE_W-1:0]  green_q,
	output logic [scu_pkg::SAMPLE_W-1:0]  blue_q
);

	logic [15:0]        off;
	logic [15:0]        upb;
	logic               v_s2, v_s3;
	logic [15:0]        y_s2, y_s3;
	logic signed [16:0] cb_s2, cr_s2;
	logic signed [34:0] pr_s3, pgb_s3, pgr_s3, pb_s3;
	logic signed [19:0] tr, tg, tb;
	logic signed [20:0] ys;

	assign off = 16'(17'(1) << (prec - 5'd1));
	assign upb = 16'((17'(1) << prec) - 17'd1);

	// Final stage terms
	assign tr = scu_pkg::trunc_q16(36'(pr_s3));
	assign tg = scu_pkg::trunc_q16(36'(pgb_s3) + 36'(pgr_s3));
	assign tb = scu_pkg::trunc_q16(36'(pb_s3));
	assign ys = $signed({5'b0, y_s3});

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s2    <= in_s1.valid;
			v_s3    <= v_s2;
			valid_q <= v_s3;
		end
	end

	// Offset removal, products, then sum, truncate and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			y_s2    <= in_s1.y;
			cb_s2   <= $signed({1'b0, in_s1.cb}) - $signed({1'b0, off});
			cr_s2   <= $signed({1'b0, in_s1.cr}) - $signed({1'b0, off});
			y_s3    <= y_s2;
			pr_s3   <= cr_s2 * scu_pkg::COEF_R;
			pgb_s3  <= cb_s2 * scu_pkg::COEF_GB;
			pgr_s3  <= cr_s2 * scu_pkg::COEF_GR;
			pb_s3   <= cb_s2 * scu_pkg::COEF_B;
			red_q   <= scu_pkg::clamp_comp(ys + 21'(tr), upb);
			green_q <= scu_pkg::clamp_comp(ys - 21'(tg), upb);
			blue_q  <= scu_pkg::clamp_comp(ys + 21'(tb), upb);
		end
	end

endmodule

// ===== rtl/sycc_to_rgb_chroma_upsample.sv =====
// An accepted item passes stage 1, the color math registers and the output register.
// Throughput: one item per cycle; the pipeline moves whenever the output
// register is empty or being taken, and the line store has one access per item.
// Reset: column, row parity, held chroma and valid bits clear; registers
// return to 4:4:4, precision 8, width 640. The line store is not cleared.
module sycc_to_rgb_chroma_upsample #(
	parameter int MAX_WIDTH   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scu_pkg::ADDR_W-1:0]  paddr,
	input  logic [scu_pkg::DATA_W-1:0]  pwdata,
	output logic [scu_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	scu_pix_in_if.sink                  pix_in,
	scu_pix_out_if.source               pix_out
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [AW-1:0] IDX_LAST = AW'(LINE_DEPTH - 1);
	localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

	scu_pkg::cfg_t     cfg;
	scu_pkg::math_in_t math_in;

	logic                       adv, in_acc, out_valid;
	logic [scu_pkg::COL_W-1:0]  col_q, col_cur, col_n;
	logic                       odd_q, odd_cur;
	logic [AW-1:0]              idx_q, idx_cur;
	logic                       take_new, take_mem, line_wr;
	logic [31:0]                incoming, rdata, held_q, pair;
	logic                       v_s1, take_new_s1, take_mem_s1;
	logic [15:0]                y_s1;
	logic [31:0]                inc_s1;

	scu_cfg_regs #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline moves when the output register is free
	assign adv          = !out_valid || pix_out.ready;
	assign pix_in.ready = adv;
	assign in_acc       = pix_in.valid && adv;

	// Position of the incoming item
	assign col_cur  = pix_in.frame_start ? '0 : col_q;
	assign odd_cur  = pix_in.frame_start ? 1'b0 : odd_q;
	assign idx_cur  = pix_in.frame_start ? '0 : idx_q;
	assign col_n    = col_cur + 13'd1;
	assign incoming = {pix_in.chroma_red & SMASK, pix_in.chroma_blue & SMASK};

	// Chroma source for this item
	always_comb begin
		take_new = 1'b0;
		take_mem = 1'b0;
		line_wr  = 1'b0;
		case (cfg.mode)
			scu_pkg::MODE_422: begin
				take_new = !col_cur[0];
			end
			scu_pkg::MODE_420: begin
				take_new = !col_cur[0] && !odd_cur;
				line_wr  = !col_cur[0] && !odd_cur;
				take_mem = !col_cur[0] && odd_cur;
			end
			default: begin
				take_new = 1'b1;
			end
		endcase
	end

	// Column, row parity and line index tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
			idx_q <= '0;
		end else if (in_acc) begin
			if ({2'b0, col_n} >= cfg.width) begin
				col_q <= '0;
				odd_q <= !odd_cur;
				idx_q <= '0;
			end else begin
				col_q <= col_n;
				odd_q <= odd_cur;
				if (col_n == '0) begin
					idx_q <= '0;
				end else if (col_cur[0]) begin
					idx_q <= (idx_cur == IDX_LAST) ? '0 : idx_cur + 1'b1;
				end else begin
					idx_q <= idx_cur;
				end
			end
		end
	end

	// Line store; even rows write and odd rows read, so one port suffices
	scu_line_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line (
		.clk   (clk),
		.wr_en (in_acc && line_wr),
		.rd_en (in_acc && take_mem),
		.addr  (idx_cur),
		.wdata (incoming),
		.rdata (rdata)
	);

	// Stage 1: item waits for the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1        <= pix_in.luma & SMASK;
			inc_s1      <= incoming;
			take_new_s1 <= take_new;
			take_mem_s1 <= take_mem;
		end
	end

	// Resolve the pair and update the held chroma in item order
	assign pair = take_mem_s1 ? rdata : (take_new_s1 ? inc_s1 : held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (adv && v_s1) begin
			held_q <= pair;
		end
	end

	assign math_in.valid = v_s1;
	assign math_in.y     = y_s1;
	assign math_in.cb    = pair[15:0];
	assign math_in.cr    = pair[31:16];

	scu_color_math u_math (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_s1   (math_in),
		.prec    (cfg.prec),
		.valid_q (out_valid),
		.red_q   (pix_out.red),
		.green_q (pix_out.green),
		.blue_q  (pix_out.blue)
	);

	assign pix_out.valid = out_valid;

	// Checks
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && line_wr && take_mem))
		else $error("line store written and read by one item");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == '0) |-> (idx_q == '0))
		else $error("line index not zero at row start");

	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted item missing from stage 1");

endmodule
